// ===== src/hpe_pkg.sv =====
// Shared types, field widths and codes of the histogram percentile engine.
package hpe_pkg;

    localparam int SAMPLE_W = 32;
    localparam int CFG_W = 32;
    localparam int NB_W = 7;
    localparam int REQ_W = 2;
    localparam int PCT_W = 14;
    localparam int FOUND_W = 6;
    localparam int OUT_W = 32;
    localparam int CFG_IDX_W = 2;

    localparam int S_DATA_W = 56;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 104;
    localparam int M_USER_W = 1;

    localparam int DEF_NUM_BUCKETS = 64;
    localparam int DEF_COUNT_WIDTH = 32;

    // One hundred percent, expressed in hundredths of a percent.
    localparam int PCT_FULL = 10000;

    localparam logic [REQ_W-1:0] REQ_ADD   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_PCT   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NBUCK = 2'd3;

    localparam logic [CFG_W-1:0] RST_MIN   = 32'h0000_0000;
    localparam logic [CFG_W-1:0] RST_MAX   = 32'hFFFF_FFFF;
    localparam logic [CFG_W-1:0] RST_WIDTH = 32'h0400_0000;
    localparam logic [NB_W-1:0]  RST_NBUCK = 7'd64;

    typedef struct packed {
        logic load_req;
        logic div_start;
        logic clamp_idx;
        logic idx_from_req;
        logic idx_zero;
        logic idx_inc;
        logic mem_rd;
        logic mem_inc;
        logic clr_wr;
        logic cnt_cap;
        logic total_clr;
        logic edge_mul;
        logic run_clr;
        logic run_acc;
        logic prod_mul;
        logic target_mul;
        logic out_load;
        logic res_ok;
        logic res_zero;
    } hpe_cmd_t;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic in_range;
        logic div_done;
        logic idx_bad;
        logic pct_bad;
        logic total_zero;
        logic hit;
        logic idx_last;
        logic sweep_last;
        logic out_free;
    } hpe_sts_t;

endpackage

// ===== src/hpe_div.sv =====
// Restoring divider producing one quotient bit per cycle.
module hpe_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [hpe_pkg::SAMPLE_W-1:0] dividend,
    input  logic [hpe_pkg::SAMPLE_W-1:0] divisor,
    output logic                         done,
    output logic [hpe_pkg::SAMPLE_W-1:0] quotient
);
    import hpe_pkg::*;

    localparam int CNT_W = $clog2(SAMPLE_W);

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [SAMPLE_W-1:0] quo_reg;
    logic [SAMPLE_W-1:0] rem_reg;
    logic [SAMPLE_W-1:0] dsr_reg;
    logic [SAMPLE_W:0]   shifted;
    logic [SAMPLE_W:0]   trial;

    always_comb
    begin
        shifted = {rem_reg, quo_reg[SAMPLE_W-1]};
        trial   = shifted - {1'b0, dsr_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(SAMPLE_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            // The partial remainder always stays below the divisor.
            if (!trial[SAMPLE_W])
            begin
                rem_reg <= trial[SAMPLE_W-1:0];
                quo_reg <= {quo_reg[SAMPLE_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[SAMPLE_W-1:0];
                quo_reg <= {quo_reg[SAMPLE_W-2:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== src/hpe_dp.sv =====
// Datapath: settings, request capture, counter memory, arithmetic and result register.
module hpe_dp #(
    parameter int NUM_BUCKETS = hpe_pkg::DEF_NUM_BUCKETS,
    parameter int COUNT_WIDTH = hpe_pkg::DEF_COUNT_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [hpe_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [hpe_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic [hpe_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic [hpe_pkg::S_USER_W-1:0]  s_tuser,
    input  hpe_pkg::hpe_cmd_t             cmd,
    output hpe_pkg::hpe_sts_t             sts,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [hpe_pkg::M_DATA_W-1:0]  m_tdata,
    output logic [hpe_pkg::M_USER_W-1:0]  m_tuser
);
    import hpe_pkg::*;

    localparam int AW  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int CW  = COUNT_WIDTH;
    localparam int IW  = (AW > NB_W) ? AW : NB_W;
    localparam int PW  = CW + PCT_W;
    localparam int EPW = CFG_W + AW;
    localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

    function automatic logic [OUT_W-1:0] sat_out(input logic [CW-1:0] v);
        logic [CW+OUT_W-1:0] w;
        w = {{OUT_W{1'b0}}, v};
        if (w > {{CW{1'b0}}, {OUT_W{1'b1}}})
        begin
            return {OUT_W{1'b1}};
        end
        return w[OUT_W-1:0];
    endfunction

    // Settings
    logic [CFG_W-1:0] min_reg;
    logic [CFG_W-1:0] max_reg;
    logic [CFG_W-1:0] width_reg;
    logic [NB_W-1:0]  nbuck_reg;

    // Captured request
    logic [REQ_W-1:0]    req_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic [NB_W-1:0]     bidx_reg;
    logic [PCT_W-1:0]    pct_reg;

    logic [AW-1:0]    idx_reg;
    logic [CW-1:0]    rdata_reg;
    logic [CW-1:0]    cnt_res_reg;
    logic [CW-1:0]    total_reg;
    logic [CW-1:0]    run_reg;
    logic [PW-1:0]    prod_reg;
    logic [PW-1:0]    target_reg;
    logic [EPW-1:0]   edge_prod_reg;
    logic             m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;
    logic [M_USER_W-1:0] m_tuser_reg;

    logic [CW-1:0]    mem [NUM_BUCKETS];

    logic [NB_W-1:0]     n_eff;
    logic [IW-1:0]       n_ext;
    logic [IW-1:0]       idx_ext;
    logic [CFG_W-1:0]    eff_width;
    logic                div_done;
    logic [SAMPLE_W-1:0] quo;
    logic [NB_W-1:0]     idx_clamp;
    logic                cnt_room;
    logic                mem_we;
    logic [CW-1:0]       mem_wdata;
    logic [CW:0]         run_sum;
    logic [CW-1:0]       run_next;
    logic [EPW:0]        edge_sum;
    logic [OUT_W-1:0]    edge_sat;
    logic [FOUND_W-1:0]  res_found;
    logic [OUT_W-1:0]    res_count;
    logic [OUT_W-1:0]    res_edge;

    always_comb
    begin
        if (nbuck_reg == '0)
        begin
            n_eff = NB_W'(1);
        end
        else if (int'(nbuck_reg) > NUM_BUCKETS)
        begin
            n_eff = NB_W'(NUM_BUCKETS);
        end
        else
        begin
            n_eff = nbuck_reg;
        end
        n_ext     = IW'(n_eff);
        idx_ext   = IW'(idx_reg);
        eff_width = (width_reg == '0) ? CFG_W'(1) : width_reg;

        // Quotients past the last bucket in use fold into it.
        if (quo >= SAMPLE_W'(n_eff))
        begin
            idx_clamp = n_eff - 1'b1;
        end
        else
        begin
            idx_clamp = quo[NB_W-1:0];
        end

        cnt_room  = (rdata_reg != CNT_MAX);
        mem_we    = cmd.clr_wr | (cmd.mem_inc & cnt_room);
        mem_wdata = cmd.clr_wr ? '0 : rdata_reg + 1'b1;

        run_sum  = {1'b0, run_reg} + {1'b0, rdata_reg};
        run_next = (run_sum > {1'b0, total_reg}) ? total_reg : run_sum[CW-1:0];

        edge_sum = {1'b0, (EPW)'(min_reg)} + {1'b0, edge_prod_reg};
        edge_sat = (edge_sum > (EPW+1)'({OUT_W{1'b1}})) ? {OUT_W{1'b1}}
                                                        : edge_sum[OUT_W-1:0];

        if (cmd.res_zero)
        begin
            res_found = '0;
            res_count = '0;
            res_edge  = '0;
        end
        else
        begin
            res_found = idx_ext[FOUND_W-1:0];
            res_count = sat_out(cnt_res_reg);
            res_edge  = edge_sat;
        end
    end

    hpe_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (sample_reg - min_reg),
        .divisor  (eff_width),
        .done     (div_done),
        .quotient (quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg   <= RST_MIN;
            max_reg   <= RST_MAX;
            width_reg <= RST_WIDTH;
            nbuck_reg <= RST_NBUCK;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_MIN:   min_reg   <= cfg_wdata;
                CFG_MAX:   max_reg   <= cfg_wdata;
                CFG_WIDTH: width_reg <= cfg_wdata;
                CFG_NBUCK: nbuck_reg <= cfg_wdata[NB_W-1:0];
                default:   ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_reg    <= s_tuser[REQ_W-1:0];
            sample_reg <= s_tdata[SAMPLE_W-1:0];
            bidx_reg   <= s_tdata[SAMPLE_W +: NB_W];
            pct_reg    <= s_tdata[SAMPLE_W + NB_W +: PCT_W];
        end
    end

    // The bucket pointer also drives the clearing sweep that follows reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else
        begin
            priority if (cmd.idx_zero)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            else if (cmd.clamp_idx)
            begin
                idx_reg <= AW'(idx_clamp);
            end
            else if (cmd.idx_from_req)
            begin
                idx_reg <= AW'(bidx_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[idx_reg] <= mem_wdata;
        end
        if (cmd.mem_rd)
        begin
            rdata_reg <= mem[idx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
        end
        else if (cmd.total_clr)
        begin
            total_reg <= '0;
        end
        else if (cmd.mem_inc && cnt_room && total_reg != CNT_MAX)
        begin
            total_reg <= total_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cnt_cap)
        begin
            cnt_res_reg <= rdata_reg;
        end
        else if (cmd.mem_inc)
        begin
            cnt_res_reg <= cnt_room ? rdata_reg + 1'b1 : rdata_reg;
        end

        if (cmd.run_clr)
        begin
            run_reg <= '0;
        end
        else if (cmd.run_acc)
        begin
            run_reg <= run_next;
        end

        if (cmd.prod_mul)
        begin
            prod_reg <= PW'(run_reg) * PW'(PCT_FULL);
        end
        if (cmd.target_mul)
        begin
            target_reg <= PW'(pct_reg) * PW'(total_reg);
        end
        if (cmd.edge_mul)
        begin
            edge_prod_reg <= EPW'(eff_width) * EPW'(idx_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            m_tdata_reg <= {2'b00, sat_out(total_reg), res_edge, res_count, res_found};
            m_tuser_reg <= M_USER_W'(cmd.res_ok);
        end
    end

    always_comb
    begin
        sts.req        = req_reg;
        sts.in_range   = (sample_reg >= min_reg) && (sample_reg <= max_reg);
        sts.div_done   = div_done;
        sts.idx_bad    = (IW'(bidx_reg) >= n_ext);
        sts.pct_bad    = (pct_reg > PCT_W'(PCT_FULL));
        sts.total_zero = (total_reg == '0);
        sts.hit        = (prod_reg >= target_reg);
        sts.idx_last   = (idx_ext == n_ext - 1'b1);
        sts.sweep_last = (idx_reg == AW'(NUM_BUCKETS - 1));
        sts.out_free   = !m_tvalid_reg || m_tready;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== src/hpe_ctrl.sv =====
// Controller: sequences each request over the datapath.
module hpe_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  hpe_pkg::hpe_sts_t sts,
    output hpe_pkg::hpe_cmd_t cmd
);
    import hpe_pkg::*;

    localparam logic [3:0] ST_RCLR = 4'd0;
    localparam logic [3:0] ST_IDLE = 4'd1;
    localparam logic [3:0] ST_DEC  = 4'd2;
    localparam logic [3:0] ST_DIV  = 4'd3;
    localparam logic [3:0] ST_ADDR = 4'd4;
    localparam logic [3:0] ST_ADDW = 4'd5;
    localparam logic [3:0] ST_RD0  = 4'd6;
    localparam logic [3:0] ST_RD1  = 4'd7;
    localparam logic [3:0] ST_CLR  = 4'd8;
    localparam logic [3:0] ST_PRD  = 4'd9;
    localparam logic [3:0] ST_PACC = 4'd10;
    localparam logic [3:0] ST_PMUL = 4'd11;
    localparam logic [3:0] ST_PCMP = 4'd12;
    localparam logic [3:0] ST_OUT  = 4'd13;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       ok_reg;
    logic       ok_next;
    logic       zero_reg;
    logic       zero_next;

    always_comb
    begin
        cmd        = '0;
        s_tready   = 1'b0;
        state_next = state_reg;
        ok_next    = ok_reg;
        zero_next  = zero_reg;

        unique case (state_reg)
            ST_RCLR:
            begin
                cmd.clr_wr = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            ST_IDLE:
            begin
                s_tready     = 1'b1;
                cmd.load_req = s_tvalid;
                if (s_tvalid)
                begin
                    state_next = ST_DEC;
                end
            end
            ST_DEC:
            begin
                // Failed requests go straight to the output state with zeroed fields.
                ok_next    = 1'b0;
                zero_next  = 1'b1;
                state_next = ST_OUT;
                unique case (sts.req)
                    REQ_ADD:
                    begin
                        if (sts.in_range)
                        begin
                            cmd.div_start = 1'b1;
                            state_next    = ST_DIV;
                        end
                    end
                    REQ_CLEAR:
                    begin
                        cmd.idx_zero  = 1'b1;
                        cmd.total_clr = 1'b1;
                        state_next    = ST_CLR;
                    end
                    REQ_READ:
                    begin
                        if (!sts.idx_bad)
                        begin
                            cmd.idx_from_req = 1'b1;
                            state_next       = ST_RD0;
                        end
                    end
                    REQ_PCT:
                    begin
                        if (!sts.pct_bad && !sts.total_zero)
                        begin
                            cmd.idx_zero   = 1'b1;
                            cmd.run_clr    = 1'b1;
                            cmd.target_mul = 1'b1;
                            state_next     = ST_PRD;
                        end
                    end
                    default: ;
                endcase
            end
            ST_DIV:
            begin
                if (sts.div_done)
                begin
                    cmd.clamp_idx = 1'b1;
                    state_next    = ST_ADDR;
                end
            end
            ST_ADDR:
            begin
                cmd.mem_rd   = 1'b1;
                cmd.edge_mul = 1'b1;
                state_next   = ST_ADDW;
            end
            ST_ADDW:
            begin
                cmd.mem_inc = 1'b1;
                ok_next     = 1'b1;
                zero_next   = 1'b0;
                state_next  = ST_OUT;
            end
            ST_RD0:
            begin
                cmd.mem_rd   = 1'b1;
                cmd.edge_mul = 1'b1;
                state_next   = ST_RD1;
            end
            ST_RD1:
            begin
                cmd.cnt_cap = 1'b1;
                ok_next     = 1'b1;
                zero_next   = 1'b0;
                state_next  = ST_OUT;
            end
            ST_CLR:
            begin
                cmd.clr_wr = 1'b1;
                if (sts.sweep_last)
                begin
                    ok_next    = 1'b1;
                    zero_next  = 1'b1;
                    state_next = ST_OUT;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            ST_PRD:
            begin
                cmd.mem_rd = 1'b1;
                state_next = ST_PACC;
            end
            ST_PACC:
            begin
                cmd.run_acc = 1'b1;
                cmd.cnt_cap = 1'b1;
                state_next  = ST_PMUL;
            end
            ST_PMUL:
            begin
                cmd.prod_mul = 1'b1;
                state_next   = ST_PCMP;
            end
            ST_PCMP:
            begin
                if (sts.hit)
                begin
                    cmd.edge_mul = 1'b1;
                    ok_next      = 1'b1;
                    zero_next    = 1'b0;
                    state_next   = ST_OUT;
                end
                else if (sts.idx_last)
                begin
                    ok_next    = 1'b0;
                    zero_next  = 1'b1;
                    state_next = ST_OUT;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_PRD;
                end
            end
            ST_OUT:
            begin
                cmd.res_ok   = ok_reg;
                cmd.res_zero = zero_reg;
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RCLR;
            ok_reg    <= 1'b0;
            zero_reg  <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ok_reg    <= ok_next;
            zero_reg  <= zero_next;
        end
    end

endmodule

// ===== src/histogram_percentile_engine.sv =====
// Top level of the histogram percentile engine: controller plus datapath.
//
//  Channel   Direction  Handshake           Contents
//  s_*       in         s_tvalid/s_tready   one request: kind in tuser, operands in tdata
//  m_*       out        m_tvalid/m_tready   one result per request
//  cfg_*     in         cfg_we only         settings write by register index
//
// An add waits on the 32-step divider, then reads and increments its bucket; a read
// fetches one counter. A percentile query walks the counter memory bucket by bucket,
// reading, accumulating, scaling and comparing each. A clear sweeps the counter memory
// at one bucket a cycle; after reset the same sweep runs before s_tready first rises.
// A finished result sits in the output register; the next request is taken meanwhile
// and its own result waits until that register has been emptied.
module histogram_percentile_engine #(
    parameter int NUM_BUCKETS = hpe_pkg::DEF_NUM_BUCKETS,
    parameter int COUNT_WIDTH = hpe_pkg::DEF_COUNT_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [hpe_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [hpe_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // sample_value[31:0], bucket_index[38:32], percentile_hundredths[52:39], zero pad
    input  logic [hpe_pkg::S_DATA_W-1:0]  s_tdata,
    // req_type[1:0]
    input  logic [hpe_pkg::S_USER_W-1:0]  s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // found_bucket[5:0], bucket_count[37:6], bucket_edge[69:38], total_count[101:70], zero pad
    output logic [hpe_pkg::M_DATA_W-1:0]  m_tdata,
    // ok[0]
    output logic [hpe_pkg::M_USER_W-1:0]  m_tuser
);
    import hpe_pkg::*;

    hpe_cmd_t cmd;
    hpe_sts_t sts;

    hpe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    hpe_dp #(
        .NUM_BUCKETS (NUM_BUCKETS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // One request at a time: an accepted request closes the input side.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while the previous one is still being worked");

    // A failed request carries zeroed bucket fields.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata[69:0] == 70'd0)
        else $error("failed result carries non-zero bucket fields");

    // No single bucket can hold more than the running total.
    a_count_le_total: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[37:6] <= m_tdata[101:70])
        else $error("bucket count exceeds total count");

endmodule
